// ===== src/assert_macros.svh =====
// Assertion helpers used by the gotb_chk checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GOTB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define GOTB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/gotb_pkg.sv =====
`timescale 1ns / 1ps
package gotb_pkg;

    localparam int GLYPH_MAX_DEF = 64;
    localparam int TEX_MAX_DEF   = 128;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_BUILD = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TOO_BIG = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CFG_OUTLINE = 3'd0,
        CFG_GRAY    = 3'd1,
        CFG_WIDE    = 3'd2,
        CFG_GW      = 3'd3,
        CFG_GH      = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OUT_NOW   = 2'd0,
        OUT_RD    = 2'd1,
        OUT_BUILD = 2'd2
    } t_out_sel;

    typedef struct packed {
        logic     start_build;
        logic     src_we;
        logic     rd_issue;
        logic     clr_step;
        logic     glyph_init;
        logic     hollow;
        logic     win_init;
        logic     tx_wr;
        logic     next_px;
        logic     out_load;
        t_out_sel out_sel;
    } t_cmd;

    typedef struct packed {
        logic too_big;
        logic rd_ok;
        logic clr_last;
        logic covered;
        logic win_last;
        logic px_last;
        logic glyph_empty;
        logic outline_zero;
        logic hollow;
        logic out_free;
    } t_stat;

endpackage

// ===== src/gotb_ram.sv =====
`timescale 1ns / 1ps
module gotb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/gotb_dp.sv =====
`timescale 1ns / 1ps
module gotb_dp import gotb_pkg::*; #(
    parameter int GLYPH_MAX = GLYPH_MAX_DEF,
    parameter int TEX_MAX   = TEX_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [2:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    input  logic [1:0]  i_mode,
    input  logic [6:0]  i_col,
    input  logic [6:0]  i_row,
    input  logic [6:0]  i_sample,
    input  logic        i_ready,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic        o_valid,
    output logic [31:0] o_texel,
    output logic [7:0]  o_tex_width,
    output logic [7:0]  o_tex_height,
    output logic [1:0]  o_status
);
    localparam int GA  = $clog2(GLYPH_MAX);
    localparam int GW  = GA + 1;
    localparam int TA  = $clog2(TEX_MAX);
    localparam int TW  = TA + 1;
    localparam int PW  = TA + 2;
    localparam int NW  = GW + 2;
    localparam int SAW = $clog2(GLYPH_MAX * GLYPH_MAX);
    localparam int TAW = $clog2(TEX_MAX * TEX_MAX);

    function automatic logic [PW-1:0] pow2_at_least(input logic [NW-1:0] need);
        logic [PW-1:0] p;
        p = PW'(1);
        for (int k = 0; k < PW; k++) begin
            if (int'(p) < int'(need) && int'(p) <= TEX_MAX) begin
                p = p << 1;
            end
        end
        return p;
    endfunction

    logic [2:0]    r_outline;
    logic [1:0]    r_gray;
    logic          r_wide;
    logic [6:0]    r_gw;
    logic [6:0]    r_gh;
    logic [TW-1:0] r_bw;
    logic [TW-1:0] r_bh;
    logic          r_built;
    logic          r_hollow;
    logic [GA-1:0] r_x;
    logic [GA-1:0] r_y;
    logic [3:0]    r_i;
    logic [3:0]    r_j;
    logic [TA-1:0] r_cx;
    logic [TA-1:0] r_cy;
    logic          r_out_valid;
    logic [31:0]   r_texel;
    logic [TW-1:0] r_ow;
    logic [TW-1:0] r_oh;
    t_status       r_ost;

    logic [GW-1:0]  w;
    logic [GW-1:0]  h;
    logic [PW-1:0]  tw_p;
    logic [PW-1:0]  th_p;
    logic           too_big;
    logic           wr_in_range;
    logic           rd_in_range;
    t_status        now_status;
    logic [3:0]     span_m1;
    logic [2:0]     off;
    logic [TW:0]    win_row;
    logic [TW:0]    win_col;
    logic [SAW-1:0] src_addr;
    logic [TAW-1:0] tex_addr;
    logic           tex_we;
    logic [31:0]    tex_wdata;
    logic [31:0]    tex_rdata;
    logic [6:0]     src_rdata;
    logic [12:0]    alpha_sh;
    logic [7:0]     alpha;
    logic [8:0]     add_sum;
    logic [7:0]     add_sat;
    logic [7:0]     sub_sat;

    assign w = (int'(r_gw) > GLYPH_MAX) ? GW'(GLYPH_MAX) : GW'(r_gw);
    assign h = (int'(r_gh) > GLYPH_MAX) ? GW'(GLYPH_MAX) : GW'(r_gh);
    assign tw_p = pow2_at_least(NW'(w) + NW'({r_outline, 1'b0}));
    assign th_p = pow2_at_least(NW'(h) + NW'({r_outline, 1'b0}));
    assign too_big = (int'(tw_p) > TEX_MAX) || (int'(th_p) > TEX_MAX);

    assign wr_in_range = (int'(i_col) < GLYPH_MAX) && (int'(i_row) < GLYPH_MAX);
    assign rd_in_range = (int'(i_col) < int'(r_bw)) && (int'(i_row) < int'(r_bh));

    always_comb begin
        unique case (t_mode'(i_mode))
            MODE_WRITE: now_status = wr_in_range ? ST_OK : ST_RANGE;
            MODE_BUILD: now_status = too_big ? ST_TOO_BIG : ST_OK;
            MODE_READ:  now_status = rd_in_range ? ST_OK : ST_RANGE;
            default:    now_status = ST_RANGE;
        endcase
    end

    assign span_m1 = {r_outline, 1'b0};
    assign off     = r_hollow ? r_outline : 3'd0;
    assign win_row = (TW+1)'(r_y) + (TW+1)'(off) + (TW+1)'(r_i);
    assign win_col = (TW+1)'(r_x) + (TW+1)'(off) + (TW+1)'(r_j);

    always_comb begin
        if (i_cmd.src_we) begin
            src_addr = SAW'(i_row) * SAW'(GLYPH_MAX) + SAW'(i_col);
        end else begin
            src_addr = SAW'(r_y) * SAW'(GLYPH_MAX) + SAW'(r_x);
        end
        if (i_cmd.clr_step) begin
            tex_addr = TAW'(r_cy) * TAW'(TEX_MAX) + TAW'(r_cx);
        end else if (i_cmd.rd_issue) begin
            tex_addr = TAW'(i_row) * TAW'(TEX_MAX) + TAW'(i_col);
        end else begin
            tex_addr = TAW'(win_row) * TAW'(TEX_MAX) + TAW'(win_col);
        end
    end

    always_comb begin
        case (r_gray)
            2'd1:    alpha_sh = {6'd0, src_rdata} << 6;
            2'd2:    alpha_sh = {6'd0, src_rdata} << 4;
            default: alpha_sh = {6'd0, src_rdata} << 2;
        endcase
        alpha   = (alpha_sh > 13'd255) ? 8'hff : alpha_sh[7:0];
        add_sum = {1'b0, tex_rdata[31:24]} + {1'b0, alpha};
        add_sat = add_sum[8] ? 8'hff : add_sum[7:0];
        sub_sat = (tex_rdata[31:24] > alpha) ? (tex_rdata[31:24] - alpha) : 8'd0;
        if (i_cmd.clr_step) begin
            tex_wdata = 32'd0;
        end else if (!r_hollow) begin
            if (!r_wide) begin
                tex_wdata = 32'h0000ffff;
            end else if (r_gray == 2'd0) begin
                tex_wdata = 32'hffffffff;
            end else begin
                tex_wdata = {add_sat, 24'hffffff};
            end
        end else begin
            if (r_gray == 2'd0 || !r_wide) begin
                tex_wdata = 32'd0;
            end else begin
                tex_wdata = {sub_sat, 24'hffffff};
            end
        end
    end

    assign tex_we = i_cmd.clr_step || i_cmd.tx_wr;

    gotb_ram #(.WIDTH(7), .DEPTH(GLYPH_MAX * GLYPH_MAX)) u_src (
        .i_clk   (i_clk),
        .i_we    (i_cmd.src_we && wr_in_range),
        .i_addr  (src_addr),
        .i_wdata (i_sample),
        .o_rdata (src_rdata)
    );

    gotb_ram #(.WIDTH(32), .DEPTH(TEX_MAX * TEX_MAX)) u_tex (
        .i_clk   (i_clk),
        .i_we    (tex_we),
        .i_addr  (tex_addr),
        .i_wdata (tex_wdata),
        .o_rdata (tex_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outline   <= 3'd0;
            r_gray      <= 2'd0;
            r_wide      <= 1'b1;
            r_gw        <= 7'd1;
            r_gh        <= 7'd1;
            r_bw        <= TW'(1);
            r_bh        <= TW'(1);
            r_built     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_OUTLINE: r_outline <= i_cfg_data[2:0];
                    CFG_GRAY:    r_gray    <= i_cfg_data[1:0];
                    CFG_WIDE:    r_wide    <= i_cfg_data[0];
                    CFG_GW:      r_gw      <= i_cfg_data;
                    CFG_GH:      r_gh      <= i_cfg_data;
                    default:     ;
                endcase
            end
            if (i_cmd.start_build) begin
                r_bw    <= TW'(tw_p);
                r_bh    <= TW'(th_p);
                r_built <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_build) begin
            r_cx <= '0;
            r_cy <= '0;
        end else if (i_cmd.clr_step) begin
            if (TW'(r_cx) == r_bw - TW'(1)) begin
                r_cx <= '0;
                r_cy <= r_cy + TA'(1);
            end else begin
                r_cx <= r_cx + TA'(1);
            end
        end
        if (i_cmd.glyph_init) begin
            r_x      <= '0;
            r_y      <= '0;
            r_hollow <= i_cmd.hollow;
        end else if (i_cmd.next_px) begin
            if (GW'(r_x) == w - GW'(1)) begin
                r_x <= '0;
                r_y <= r_y + GA'(1);
            end else begin
                r_x <= r_x + GA'(1);
            end
        end
        if (i_cmd.win_init) begin
            r_i <= 4'd0;
            r_j <= 4'd0;
        end else if (i_cmd.tx_wr) begin
            if (r_j == span_m1) begin
                r_j <= 4'd0;
                r_i <= r_i + 4'd1;
            end else begin
                r_j <= r_j + 4'd1;
            end
        end
        if (i_cmd.out_load) begin
            r_ow <= i_cmd.start_build ? TW'(tw_p) : r_bw;
            r_oh <= i_cmd.start_build ? TW'(th_p) : r_bh;
            case (i_cmd.out_sel)
                OUT_RD: begin
                    r_texel <= tex_rdata;
                    r_ost   <= ST_OK;
                end
                OUT_BUILD: begin
                    r_texel <= 32'd0;
                    r_ost   <= ST_OK;
                end
                default: begin
                    r_texel <= 32'd0;
                    r_ost   <= now_status;
                end
            endcase
        end
    end

    assign o_stat.too_big      = too_big;
    assign o_stat.rd_ok        = rd_in_range && r_built;
    assign o_stat.clr_last     = (TW'(r_cx) == r_bw - TW'(1)) && (TW'(r_cy) == r_bh - TW'(1));
    assign o_stat.covered      = (src_rdata != 7'd0);
    assign o_stat.win_last     = r_hollow || ((r_i == span_m1) && (r_j == span_m1));
    assign o_stat.px_last      = (GW'(r_x) == w - GW'(1)) && (GW'(r_y) == h - GW'(1));
    assign o_stat.glyph_empty  = (w == '0) || (h == '0);
    assign o_stat.outline_zero = (r_outline == 3'd0);
    assign o_stat.hollow       = r_hollow;
    assign o_stat.out_free     = !r_out_valid || i_ready;

    assign o_valid      = r_out_valid;
    assign o_texel      = r_texel;
    assign o_tex_width  = 8'(r_ow);
    assign o_tex_height = 8'(r_oh);
    assign o_status     = r_ost;
endmodule

// ===== src/gotb_ctrl.sv =====
`timescale 1ns / 1ps
module gotb_ctrl import gotb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_mode,
    input  t_stat      i_stat,
    output logic       o_ready,
    output t_cmd       o_cmd
);
    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_RDWAIT  = 7'b0000010,
        S_CLR     = 7'b0000100,
        S_SRC_RD  = 7'b0001000,
        S_SRC_CHK = 7'b0010000,
        S_TX_RD   = 7'b0100000,
        S_TX_WR   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   take;
    logic   phase_end;

    assign o_ready = (r_state == S_IDLE) && i_stat.out_free;
    assign take    = i_valid && o_ready;

    always_comb begin
        o_cmd         = '0;
        o_cmd.out_sel = OUT_NOW;
        n_state       = r_state;
        phase_end     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    unique case (t_mode'(i_mode))
                        MODE_WRITE: begin
                            o_cmd.src_we   = 1'b1;
                            o_cmd.out_load = 1'b1;
                        end
                        MODE_BUILD: begin
                            if (i_stat.too_big) begin
                                o_cmd.out_load = 1'b1;
                            end else begin
                                o_cmd.start_build = 1'b1;
                                n_state = S_CLR;
                            end
                        end
                        MODE_READ: begin
                            if (i_stat.rd_ok) begin
                                o_cmd.rd_issue = 1'b1;
                                n_state = S_RDWAIT;
                            end else begin
                                o_cmd.out_load = 1'b1;
                            end
                        end
                        default: o_cmd.out_load = 1'b1;
                    endcase
                end
            end
            S_RDWAIT: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_sel  = OUT_RD;
                n_state = S_IDLE;
            end
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    if (i_stat.glyph_empty) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_sel  = OUT_BUILD;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.glyph_init = 1'b1;
                        n_state = S_SRC_RD;
                    end
                end
            end
            S_SRC_RD: n_state = S_SRC_CHK;
            S_SRC_CHK: begin
                if (i_stat.covered) begin
                    o_cmd.win_init = 1'b1;
                    n_state = S_TX_RD;
                end else begin
                    o_cmd.next_px = 1'b1;
                    phase_end = i_stat.px_last;
                    n_state = S_SRC_RD;
                end
            end
            S_TX_RD: n_state = S_TX_WR;
            S_TX_WR: begin
                o_cmd.tx_wr = 1'b1;
                if (i_stat.win_last) begin
                    o_cmd.next_px = 1'b1;
                    phase_end = i_stat.px_last;
                    n_state = S_SRC_RD;
                end else begin
                    n_state = S_TX_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (phase_end) begin
            if (!i_stat.hollow && !i_stat.outline_zero) begin
                o_cmd.glyph_init = 1'b1;
                o_cmd.hollow     = 1'b1;
                n_state = S_SRC_RD;
            end else begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_sel  = OUT_BUILD;
                n_state = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ===== src/glyph_outline_texture_builder_core.sv =====
// Sample write, unused mode, refused build, out-of-range read: registered when accepted.
// Texel read: one texture memory read, then the result register. Writes sustain one request
// per cycle unless the output stalls. Build clears all tw*th texels, writes a (2*outline+1)^2
// window per covered glyph sample, then (outline nonzero) a hollow pass per covered sample;
// bound by the single texture memory port doing read-modify-write. Reset is synchronous,
// active low, and sets registers to defaults, built size 1x1 reading zero; no clearing pass.
`timescale 1ns / 1ps
module glyph_outline_texture_builder_core import gotb_pkg::*; #(
    parameter int GLYPH_MAX = GLYPH_MAX_DEF,
    parameter int TEX_MAX   = TEX_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [6:0]  i_col,
    input  logic [6:0]  i_row,
    input  logic [6:0]  i_sample,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_texel,
    output logic [7:0]  o_tex_width,
    output logic [7:0]  o_tex_height,
    output logic [1:0]  o_status
);
    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    gotb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_mode  (i_mode),
        .i_stat  (stat),
        .o_ready (o_ready),
        .o_cmd   (cmd)
    );

    gotb_dp #(.GLYPH_MAX(GLYPH_MAX), .TEX_MAX(TEX_MAX)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_mode       (i_mode),
        .i_col        (i_col),
        .i_row        (i_row),
        .i_sample     (i_sample),
        .i_ready      (i_ready),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_valid      (o_valid),
        .o_texel      (o_texel),
        .o_tex_width  (o_tex_width),
        .o_tex_height (o_tex_height),
        .o_status     (o_status)
    );
endmodule

// ===== src/gotb_chk.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gotb_chk import gotb_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_tex_width,
    input logic [7:0]  o_tex_height
);
    `GOTB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid, "result dropped")
    `GOTB_ASSERT_NOW(a_no_overrun, i_clk, i_rst_n, o_ready, !o_valid || i_ready, "overrun")
    `GOTB_ASSERT_NOW(a_pow2_w, i_clk, i_rst_n, o_valid, $onehot(o_tex_width), "bad width")
    `GOTB_ASSERT_NOW(a_pow2_h, i_clk, i_rst_n, o_valid, $onehot(o_tex_height), "bad height")
endmodule

bind glyph_outline_texture_builder_core gotb_chk u_gotb_chk (.*);

// ===== tb/gotb_checker.sv =====
`timescale 1ns / 1ps
module gotb_checker import gotb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [1:0]  i_mode,
    input  logic [6:0]  i_col,
    input  logic [6:0]  i_row,
    input  logic [6:0]  i_sample,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [31:0] i_texel,
    input  logic [7:0]  i_tex_width,
    input  logic [7:0]  i_tex_height,
    input  logic [1:0]  i_status,
    output int          o_errors,
    output int          o_pending,
    output int          o_built_w,
    output int          o_built_h
);

    localparam int GMAX = GLYPH_MAX_DEF;
    localparam int TMAX = TEX_MAX_DEF;

    typedef struct {
        logic [31:0] texel;
        logic [7:0]  width;
        logic [7:0]  height;
        logic [1:0]  status;
    } t_answer;

    logic [6:0]  glyph_src [0:GMAX*GMAX-1];
    logic [31:0] texture [0:TMAX*TMAX-1];
    int          built_w;
    int          built_h;
    int          outline;
    int          gray;
    int          wide;
    int          glyph_w;
    int          glyph_h;
    t_answer     answer_q[$];
    int          errors;

    assign o_errors  = errors;
    assign o_pending = answer_q.size();
    assign o_built_w = built_w;
    assign o_built_h = built_h;

    initial begin
        foreach (glyph_src[k]) glyph_src[k] = '0;
        foreach (texture[k]) texture[k] = '0;
        built_w = 1;
        built_h = 1;
        outline = 0;
        gray    = 0;
        wide    = 1;
        glyph_w = 1;
        glyph_h = 1;
        errors  = 0;
    end

    function automatic int alpha_of(int s);
        int a;
        a = s << (8 - 2 * gray);
        return (a > 255) ? 255 : a;
    endfunction

    function automatic t_status run_build();
        int w, h, o, span, tw, th, x, y, i, j, s, a, na, cur, idx;
        w = (glyph_w > GMAX) ? GMAX : glyph_w;
        h = (glyph_h > GMAX) ? GMAX : glyph_h;
        o = outline;
        span = 2 * o + 1;
        tw = 1;
        while (tw < w + 2 * o && tw <= TMAX) tw = tw << 1;
        th = 1;
        while (th < h + 2 * o && th <= TMAX) th = th << 1;
        if (tw > TMAX || th > TMAX) return ST_TOO_BIG;
        built_w = tw;
        built_h = th;
        foreach (texture[k]) texture[k] = '0;
        for (y = 0; y < h; y++) begin
            for (x = 0; x < w; x++) begin
                s = glyph_src[y * GMAX + x];
                a = 0;
                if (gray == 0) begin
                    if (s == 0) continue;
                end else begin
                    a = alpha_of(s);
                    if (a == 0) continue;
                end
                for (i = 0; i < span; i++) begin
                    for (j = 0; j < span; j++) begin
                        idx = (y + i) * TMAX + (x + j);
                        if (!wide) begin
                            texture[idx] = 32'h0000ffff;
                        end else if (gray == 0) begin
                            texture[idx] = 32'hffffffff;
                        end else begin
                            na = texture[idx][31:24] + a;
                            if (na > 255) na = 255;
                            texture[idx] = {na[7:0], 24'hffffff};
                        end
                    end
                end
            end
        end
        if (o > 0) begin
            for (y = 0; y < h; y++) begin
                for (x = 0; x < w; x++) begin
                    s = glyph_src[y * GMAX + x];
                    idx = (y + o) * TMAX + (x + o);
                    if (gray == 0) begin
                        if (s != 0) texture[idx] = '0;
                    end else begin
                        a = alpha_of(s);
                        if (a == 0) continue;
                        if (!wide) begin
                            texture[idx] = '0;
                        end else begin
                            cur = texture[idx][31:24];
                            na = (cur > a) ? cur - a : 0;
                            texture[idx] = {na[7:0], 24'hffffff};
                        end
                    end
                end
            end
        end
        return ST_OK;
    endfunction

    function automatic t_answer apply_request(logic [1:0] mode, int col, int row, int smp);
        t_answer r;
        r.texel  = '0;
        r.status = ST_OK;
        case (t_mode'(mode))
            MODE_WRITE: begin
                if (col < GMAX && row < GMAX) glyph_src[row * GMAX + col] = smp[6:0];
                else r.status = ST_RANGE;
            end
            MODE_BUILD: r.status = run_build();
            MODE_READ: begin
                if (col < built_w && row < built_h) r.texel = texture[row * TMAX + col];
                else r.status = ST_RANGE;
            end
            default: r.status = ST_RANGE;
        endcase
        r.width  = built_w[7:0];
        r.height = built_h[7:0];
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_answer w;
        if (i_rst_n) begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (answer_q.size() == 0) begin
                    report("unexpected response", i_texel, 0);
                end else begin
                    w = answer_q.pop_front();
                    if (i_texel !== w.texel) report("texel", i_texel, w.texel);
                    if (i_tex_width !== w.width) report("tex_width", i_tex_width, w.width);
                    if (i_tex_height !== w.height) report("tex_height", i_tex_height, w.height);
                    if (i_status !== w.status) report("status", i_status, w.status);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_OUTLINE: outline = i_cfg_data[2:0];
                    CFG_GRAY:    gray    = i_cfg_data[1:0];
                    CFG_WIDE:    wide    = i_cfg_data[0];
                    CFG_GW:      glyph_w = i_cfg_data;
                    CFG_GH:      glyph_h = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready)
                answer_q.push_back(apply_request(i_mode, i_col, i_row, i_sample));
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import gotb_pkg::*;

    localparam int LIMIT = 6000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [6:0]  i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_mode;
    logic [6:0]  i_col;
    logic [6:0]  i_row;
    logic [6:0]  i_sample;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_texel;
    logic [7:0]  o_tex_width;
    logic [7:0]  o_tex_height;
    logic [1:0]  o_status;

    int          errors;
    int          pending;
    int          built_w;
    int          built_h;
    int          cycles = 0;
    int          stall_cnt = 0;
    int          n_sent;
    bit          gaps_on;
    bit          stalls_on;
    bit          written [0:4095];
    int          cur_w;
    int          cur_h;

    glyph_outline_texture_builder_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_mode(i_mode), .i_col(i_col), .i_row(i_row), .i_sample(i_sample),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_texel(o_texel), .o_tex_width(o_tex_width),
        .o_tex_height(o_tex_height), .o_status(o_status)
    );

    gotb_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_req_valid(i_valid), .i_req_ready(o_ready),
        .i_mode(i_mode), .i_col(i_col), .i_row(i_row), .i_sample(i_sample),
        .i_rsp_valid(o_valid), .i_rsp_ready(i_ready),
        .i_texel(o_texel), .i_tex_width(o_tex_width),
        .i_tex_height(o_tex_height), .i_status(o_status),
        .o_errors(errors), .o_pending(pending),
        .o_built_w(built_w), .o_built_h(built_h)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_cnt == 0) begin
            i_ready   <= !(stalls_on && $urandom_range(0, 2) == 0);
            stall_cnt <= $urandom_range(1, 10);
        end else begin
            stall_cnt <= stall_cnt - 1;
        end
    end

    task automatic send_req(t_mode mode, int col, int row, int smp);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_mode   <= mode;
        i_col    <= col[6:0];
        i_row    <= row[6:0];
        i_sample <= smp[6:0];
        if (mode == MODE_WRITE && col < 64 && row < 64) written[row * 64 + col] = 1'b1;
        n_sent++;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data[6:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // hold requests until the block is idle, then load a full register set
    task automatic set_glyph(int o, int g, int wd, int gw, int gh);
        wait_idle();
        write_reg(CFG_OUTLINE, o);
        write_reg(CFG_GRAY, g);
        write_reg(CFG_WIDE, wd);
        write_reg(CFG_GW, gw);
        write_reg(CFG_GH, gh);
        i_cfg_valid <= 1'b0;
        cur_w = (gw > 64) ? 64 : gw;
        cur_h = (gh > 64) ? 64 : gh;
    endtask

    function automatic int rand_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return 0;
        if (r == 9) return $urandom_range(0, 127);
        return $urandom_range(0, 64);
    endfunction

    task automatic fill_box();
        for (int r = 0; r < cur_h; r++)
            for (int c = 0; c < cur_w; c++)
                if (!written[r * 64 + c]) send_req(MODE_WRITE, c, r, rand_sample());
    endtask

    task automatic read_some(int n);
        for (int k = 0; k < n; k++)
            send_req(MODE_READ, $urandom_range(0, built_w - 1), $urandom_range(0, built_h - 1), 0);
    endtask

    task automatic random_phase(int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                send_req(MODE_WRITE, $urandom_range(0, cur_w > 0 ? cur_w - 1 : 0),
                         $urandom_range(0, cur_h > 0 ? cur_h - 1 : 0), rand_sample());
            end else if (r < 45) begin
                fill_box();
                send_req(MODE_BUILD, $urandom_range(0, 127), $urandom_range(0, 127),
                         $urandom_range(0, 127));
            end else if (r < 85) begin
                read_some(1);
            end else if (r < 91) begin
                send_req(MODE_READ, $urandom_range(0, 127), $urandom_range(0, 127),
                         $urandom_range(0, 127));
            end else if (r < 97) begin
                send_req(MODE_WRITE, $urandom_range(0, 127), $urandom_range(0, 127),
                         rand_sample());
            end else begin
                send_req(MODE_NONE, $urandom_range(0, 127), $urandom_range(0, 127),
                         $urandom_range(0, 127));
            end
        end
    endtask

    initial begin
        foreach (written[k]) written[k] = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_mode      = MODE_WRITE;
        i_col       = '0;
        i_row       = '0;
        i_sample    = '0;
        n_sent      = 0;
        gaps_on     = 1'b1;
        stalls_on   = 1'b1;
        cur_w       = 1;
        cur_h       = 1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_req(MODE_READ, 0, 0, 0);
        send_req(MODE_WRITE, 0, 0, 64);
        send_req(MODE_BUILD, 0, 0, 0);
        send_req(MODE_READ, 0, 0, 0);
        send_req(MODE_READ, 1, 0, 0);
        send_req(MODE_READ, 0, 127, 0);
        send_req(MODE_WRITE, 127, 0, 1);
        send_req(MODE_WRITE, 0, 64, 1);
        send_req(MODE_WRITE, 63, 63, 127);
        send_req(MODE_NONE, 127, 127, 127);

        set_glyph(7, 3, 1, 64, 2);
        fill_box();
        send_req(MODE_BUILD, 0, 0, 0);
        read_some(20);
        set_glyph(0, 0, 0, 2, 64);
        fill_box();
        send_req(MODE_BUILD, 0, 0, 0);
        read_some(10);
        set_glyph(7, 1, 0, 3, 3);
        send_req(MODE_WRITE, 1, 1, 0);
        send_req(MODE_WRITE, 0, 0, 127);
        fill_box();
        send_req(MODE_BUILD, 0, 0, 0);
        read_some(10);
        set_glyph(3, 2, 1, 0, 5);
        send_req(MODE_BUILD, 0, 0, 0);
        read_some(4);
        set_glyph(1, 2, 1, 100, 1);
        fill_box();
        send_req(MODE_BUILD, 0, 0, 0);
        read_some(10);
        set_glyph(2, 1, 1, 4, 127);
        fill_box();
        send_req(MODE_BUILD, 0, 0, 0);
        read_some(10);

        while (n_sent < 1000) begin
            if (n_sent > 880) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            set_glyph($urandom_range(0, 7), $urandom_range(0, 3), $urandom_range(0, 1),
                      $urandom_range(1, 6), $urandom_range(1, 6));
            fill_box();
            send_req(MODE_BUILD, 0, 0, 0);
            random_phase(50);
        end

        wait_idle();
        repeat (50) @(posedge i_clk);
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

endmodule
